// File: rtl/core/dirty_rectangle_tracker_core_defines.svh
// Assertion macros shared by the dirty rectangle tracker checker.
`ifndef DIRTY_RECTANGLE_TRACKER_CORE_DEFINES_SVH
`define DIRTY_RECTANGLE_TRACKER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define DRT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DRT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/drt_pkg.sv
// Shared types and constants of the dirty rectangle tracker.
package drt_pkg;

	localparam int MAX_RECTS = 16;
	localparam int IDX_W     = $clog2(MAX_RECTS);
	localparam int CNT_W     = $clog2(MAX_RECTS + 1);

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_TEST  = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_APPEND,
		ST_FULL_MERGE,
		ST_READ,
		ST_BOUND,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ADDR_SCAN,
		ADDR_ZERO,
		ADDR_COUNT,
		ADDR_INDEX
	} addr_sel_t;

	typedef struct packed {
		logic      load_item;
		addr_sel_t addr_sel;
		logic      wr_en;
		logic      wr_item;
		logic      clr_idx;
		logic      inc_idx;
		logic      clr_count;
		logic      inc_count;
		logic      set_hit;
		logic      ld_entry;
		logic      bnd_step;
		logic      load_out;
	} ctl_t;

	typedef struct packed {
		kind_t kind;
		logic  size_ok;
		logic  idx_end;
		logic  hit_now;
		logic  full;
		logic  out_free;
	} sts_t;

endpackage

// File: rtl/core/drt_ctrl.sv
// Sequencer of the dirty rectangle tracker: scans where needed, then bound pass per word.
module drt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  drt_pkg::sts_t sts,
	output drt_pkg::ctl_t ctl
);

	drt_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		ctl          = '0;
		ctl.addr_sel = drt_pkg::ADDR_SCAN;
		in_stall     = 1'b1;
		unique case (state_q)
			drt_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.load_item = 1'b1;
					state_d       = drt_pkg::ST_DECODE;
				end
			end
			drt_pkg::ST_DECODE: begin
				ctl.clr_idx = 1'b1;
				unique case (sts.kind)
					drt_pkg::KIND_ADD: begin
						state_d = sts.size_ok ? drt_pkg::ST_SCAN : drt_pkg::ST_BOUND;
					end
					drt_pkg::KIND_CLEAR: begin
						ctl.clr_count = 1'b1;
						state_d       = drt_pkg::ST_BOUND;
					end
					drt_pkg::KIND_TEST: begin
						state_d = drt_pkg::ST_SCAN;
					end
					drt_pkg::KIND_READ: begin
						state_d = drt_pkg::ST_READ;
					end
					default: begin
						state_d = drt_pkg::ST_BOUND;
					end
				endcase
			end
			drt_pkg::ST_SCAN: begin
				if (sts.idx_end) begin
					if (sts.kind == drt_pkg::KIND_ADD) begin
						state_d = sts.full ? drt_pkg::ST_FULL_MERGE : drt_pkg::ST_APPEND;
					end else begin
						ctl.clr_idx = 1'b1;
						state_d     = drt_pkg::ST_BOUND;
					end
				end else if (sts.hit_now && sts.kind == drt_pkg::KIND_ADD) begin
					ctl.wr_en   = 1'b1;
					ctl.clr_idx = 1'b1;
					state_d     = drt_pkg::ST_BOUND;
				end else begin
					ctl.set_hit = sts.hit_now;
					ctl.inc_idx = 1'b1;
				end
			end
			drt_pkg::ST_APPEND: begin
				ctl.addr_sel  = drt_pkg::ADDR_COUNT;
				ctl.wr_en     = 1'b1;
				ctl.wr_item   = 1'b1;
				ctl.inc_count = 1'b1;
				ctl.clr_idx   = 1'b1;
				state_d       = drt_pkg::ST_BOUND;
			end
			drt_pkg::ST_FULL_MERGE: begin
				ctl.addr_sel = drt_pkg::ADDR_ZERO;
				ctl.wr_en    = 1'b1;
				ctl.clr_idx  = 1'b1;
				state_d      = drt_pkg::ST_BOUND;
			end
			drt_pkg::ST_READ: begin
				ctl.addr_sel = drt_pkg::ADDR_INDEX;
				ctl.ld_entry = 1'b1;
				ctl.clr_idx  = 1'b1;
				state_d      = drt_pkg::ST_BOUND;
			end
			drt_pkg::ST_BOUND: begin
				if (sts.idx_end) begin
					state_d = drt_pkg::ST_DONE;
				end else begin
					ctl.bnd_step = 1'b1;
					ctl.inc_idx  = 1'b1;
				end
			end
			drt_pkg::ST_DONE: begin
				if (sts.out_free) begin
					ctl.load_out = 1'b1;
					state_d      = drt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = drt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/core/drt_datapath.sv
// Datapath of the dirty rectangle tracker: entry table, overlap and union logic, output word.
module drt_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  drt_pkg::ctl_t       ctl,
	output drt_pkg::sts_t       sts,
	input  logic [1:0]          kind,
	input  logic signed [15:0]  rect_x,
	input  logic signed [15:0]  rect_y,
	input  logic signed [15:0]  rect_width,
	input  logic signed [15:0]  rect_height,
	input  logic [3:0]          entry_index,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [4:0]          entry_count,
	output logic                overlap_hit,
	output logic signed [15:0]  bound_x,
	output logic signed [15:0]  bound_y,
	output logic [16:0]         bound_width,
	output logic [16:0]         bound_height,
	output logic                entry_valid,
	output logic signed [15:0]  entry_x,
	output logic signed [15:0]  entry_y,
	output logic [16:0]         entry_width,
	output logic [16:0]         entry_height
);

	localparam int IW = drt_pkg::IDX_W;
	localparam int CW = drt_pkg::CNT_W;

	// entry table, no reset: only entries below the count are ever read out
	logic signed [15:0] left_q [drt_pkg::MAX_RECTS];
	logic signed [15:0] top_q  [drt_pkg::MAX_RECTS];
	logic [16:0]        wid_q  [drt_pkg::MAX_RECTS];
	logic [16:0]        hgt_q  [drt_pkg::MAX_RECTS];

	logic [1:0]         kind_q;
	logic signed [15:0] rx_q, ry_q, rw_q, rh_q;
	logic [3:0]         ridx_q;
	logic [CW-1:0]      count_q, idx_q;
	logic               hit_q;
	logic               ev_q;
	logic signed [15:0] ex_q, ey_q;
	logic [16:0]        ew_q, eh_q;
	logic signed [15:0] bl_q, bt_q;
	logic signed [17:0] br_q, bb_q;
	logic               out_valid_q;

	logic [IW-1:0]      addr;
	logic signed [15:0] e_l, e_t, m_l, m_t, o_l, o_t;
	logic [16:0]        e_w, e_h;
	logic signed [17:0] e_r, e_b, i_r, i_b, m_r, m_b, o_r, o_b;
	logic               hit_now;

	always_comb begin
		unique case (ctl.addr_sel)
			drt_pkg::ADDR_SCAN:  addr = idx_q[IW-1:0];
			drt_pkg::ADDR_ZERO:  addr = '0;
			drt_pkg::ADDR_COUNT: addr = count_q[IW-1:0];
			drt_pkg::ADDR_INDEX: addr = IW'(ridx_q);
			default:             addr = '0;
		endcase
	end

	assign e_l = left_q[addr];
	assign e_t = top_q[addr];
	assign e_w = wid_q[addr];
	assign e_h = hgt_q[addr];
	assign e_r = 18'(e_l) + $signed({1'b0, e_w});
	assign e_b = 18'(e_t) + $signed({1'b0, e_h});
	assign i_r = 18'(rx_q) + 18'(rw_q);
	assign i_b = 18'(ry_q) + 18'(rh_q);

	// strict overlap: intersection has positive width and height
	assign o_l = (e_l > rx_q) ? e_l : rx_q;
	assign o_t = (e_t > ry_q) ? e_t : ry_q;
	assign o_r = (e_r < i_r) ? e_r : i_r;
	assign o_b = (e_b < i_b) ? e_b : i_b;
	assign hit_now = (18'(o_l) < o_r) && (18'(o_t) < o_b);

	// bounding-box union of the addressed entry and the held rectangle
	assign m_l = (e_l < rx_q) ? e_l : rx_q;
	assign m_t = (e_t < ry_q) ? e_t : ry_q;
	assign m_r = (e_r > i_r) ? e_r : i_r;
	assign m_b = (e_b > i_b) ? e_b : i_b;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			if (ctl.wr_item) begin
				left_q[addr] <= rx_q;
				top_q[addr]  <= ry_q;
				wid_q[addr]  <= {1'b0, rw_q};
				hgt_q[addr]  <= {1'b0, rh_q};
			end else begin
				left_q[addr] <= m_l;
				top_q[addr]  <= m_t;
				wid_q[addr]  <= 17'(m_r - 18'(m_l));
				hgt_q[addr]  <= 17'(m_b - 18'(m_t));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			kind_q <= kind;
			rx_q   <= rect_x;
			ry_q   <= rect_y;
			rw_q   <= rect_width;
			rh_q   <= rect_height;
			ridx_q <= entry_index;
			hit_q  <= 1'b0;
			ev_q   <= 1'b0;
			ex_q   <= '0;
			ey_q   <= '0;
			ew_q   <= '0;
			eh_q   <= '0;
		end else begin
			if (ctl.set_hit) begin
				hit_q <= 1'b1;
			end
			if (ctl.ld_entry && (CW'(ridx_q) < count_q)) begin
				ev_q <= 1'b1;
				ex_q <= e_l;
				ey_q <= e_t;
				ew_q <= e_w;
				eh_q <= e_h;
			end
		end
		if (ctl.bnd_step) begin
			if (idx_q == '0) begin
				bl_q <= e_l;
				bt_q <= e_t;
				br_q <= e_r;
				bb_q <= e_b;
			end else begin
				bl_q <= (e_l < bl_q) ? e_l : bl_q;
				bt_q <= (e_t < bt_q) ? e_t : bt_q;
				br_q <= (e_r > br_q) ? e_r : br_q;
				bb_q <= (e_b > bb_q) ? e_b : bb_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (ctl.clr_count) begin
				count_q <= '0;
			end else if (ctl.inc_count) begin
				count_q <= count_q + 1'b1;
			end
			if (ctl.clr_idx) begin
				idx_q <= '0;
			end else if (ctl.inc_idx) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			entry_count  <= 5'(count_q);
			overlap_hit  <= hit_q;
			entry_valid  <= ev_q;
			entry_x      <= ex_q;
			entry_y      <= ey_q;
			entry_width  <= ew_q;
			entry_height <= eh_q;
			if (count_q == '0) begin
				bound_x      <= '0;
				bound_y      <= '0;
				bound_width  <= '0;
				bound_height <= '0;
			end else begin
				bound_x      <= bl_q;
				bound_y      <= bt_q;
				bound_width  <= 17'(br_q - 18'(bl_q));
				bound_height <= 17'(bb_q - 18'(bt_q));
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.kind     = drt_pkg::kind_t'(kind_q);
	assign sts.size_ok  = (rw_q > 16'sd0) && (rh_q > 16'sd0);
	assign sts.idx_end  = (idx_q == count_q);
	assign sts.hit_now  = hit_now;
	assign sts.full     = (count_q == CW'(drt_pkg::MAX_RECTS));
	assign sts.out_free = !out_valid_q || !out_stall;

endmodule

// File: rtl/core/dirty_rectangle_tracker_core.sv
// Top level of the dirty rectangle tracker: sequencer plus table datapath.
//
// Input channel (in_valid / in_stall) takes one word per command: add, clear,
// test overlap or read entry, with a rectangle and an entry index. Output
// channel (out_valid / out_stall) returns one word per command with the count,
// the test hit, the union of all entries and the read entry.
// A word is moved on a rising edge with valid high and stall low.
//
// Sequencing: one command is worked on at a time. The sequencer accepts the
// word, decodes it, scans the table for add and test, appends, merges into
// entry zero or reads where the command calls for it, folds the union over
// the table, and then loads the output register. An add hit merges in place.
// in_stall is low only while the sequencer waits for a command, so the next
// word is taken as soon as the previous one sits in the output register.
//
// Reset (arst_n low) empties the table and drops any pending output word.
// While out_stall is high the output word holds; a finished command waits
// in the done state until the output register frees up.
module dirty_rectangle_tracker_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          kind,
	input  logic signed [15:0]  rect_x,
	input  logic signed [15:0]  rect_y,
	input  logic signed [15:0]  rect_width,
	input  logic signed [15:0]  rect_height,
	input  logic [3:0]          entry_index,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [4:0]          entry_count,
	output logic                overlap_hit,
	output logic signed [15:0]  bound_x,
	output logic signed [15:0]  bound_y,
	output logic [16:0]         bound_width,
	output logic [16:0]         bound_height,
	output logic                entry_valid,
	output logic signed [15:0]  entry_x,
	output logic signed [15:0]  entry_y,
	output logic [16:0]         entry_width,
	output logic [16:0]         entry_height
);

	// command and status between sequencer and datapath
	drt_pkg::ctl_t ctl;
	drt_pkg::sts_t sts;

	drt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	drt_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.kind         (kind),
		.rect_x       (rect_x),
		.rect_y       (rect_y),
		.rect_width   (rect_width),
		.rect_height  (rect_height),
		.entry_index  (entry_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.entry_count  (entry_count),
		.overlap_hit  (overlap_hit),
		.bound_x      (bound_x),
		.bound_y      (bound_y),
		.bound_width  (bound_width),
		.bound_height (bound_height),
		.entry_valid  (entry_valid),
		.entry_x      (entry_x),
		.entry_y      (entry_y),
		.entry_width  (entry_width),
		.entry_height (entry_height)
	);

endmodule

// File: rtl/core/drt_checker.sv
// Port-level assertions of the dirty rectangle tracker and their bind.
`include "dirty_rectangle_tracker_core_defines.svh"

module drt_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [4:0]          entry_count,
	input logic signed [15:0]  bound_x,
	input logic signed [15:0]  bound_y,
	input logic [16:0]         bound_width,
	input logic [16:0]         bound_height,
	input logic                entry_valid,
	input logic signed [15:0]  entry_x,
	input logic signed [15:0]  entry_y,
	input logic [16:0]         entry_width,
	input logic [16:0]         entry_height
);

	`DRT_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid && !in_stall, "output or stall active in reset")

	`DRT_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "second word taken while busy")

	`DRT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(entry_count) && $stable(bound_width) && $stable(entry_x), "stalled output word changed")

	`DRT_ASSERT(a_empty_bound, out_valid && entry_count == 5'd0 |-> bound_x == 16'sd0 && bound_y == 16'sd0 && bound_width == 17'd0 && bound_height == 17'd0 && !entry_valid, "empty table with nonzero bound")

	`DRT_ASSERT(a_read_zero, out_valid && !entry_valid |-> entry_x == 16'sd0 && entry_y == 16'sd0 && entry_width == 17'd0 && entry_height == 17'd0, "invalid read with nonzero entry")

endmodule

bind dirty_rectangle_tracker_core drt_checker u_drt_checker (.*);
